### rtl/tbpe_pkg.sv
// Package with the shared types, segment codes and timing constants of the tape pulse encoder.
`default_nettype none

package tbpe_pkg;

   // Segment kind codes as seen on the result channel.
   localparam logic [2:0] KIND_PILOT = 3'd0;
   localparam logic [2:0] KIND_SYNC  = 3'd1;
   localparam logic [2:0] KIND_ZERO  = 3'd2;
   localparam logic [2:0] KIND_ONE   = 3'd3;
   localparam logic [2:0] KIND_END   = 3'd4;

   // Pilot repeat counts for header and data blocks.
   localparam logic [12:0] PILOT_HEADER_COUNT = 13'd8063;
   localparam logic [12:0] PILOT_DATA_COUNT   = 13'd3223;
   localparam logic [12:0] SINGLE_COUNT       = 13'd1;

   // Half-period and pause lengths, in units of CPU ticks.
   localparam longint unsigned TicksPilotL    = 64'd2168;
   localparam longint unsigned TicksSyncHighL = 64'd667;
   localparam longint unsigned TicksSyncLowL  = 64'd735;
   localparam longint unsigned TicksEndHighL  = 64'd954;
   localparam longint unsigned TicksZeroL     = 64'd855;
   localparam longint unsigned TicksOneL      = 64'd1710;
   localparam longint unsigned TicksPauseL    = 64'd2168 * 64'd3223;

   localparam logic [11:0] TICKS_PILOT     = 12'(TicksPilotL);
   localparam logic [11:0] TICKS_SYNC_HIGH = 12'(TicksSyncHighL);
   localparam logic [22:0] TICKS_SYNC_LOW  = 23'(TicksSyncLowL);
   localparam logic [11:0] TICKS_END_HIGH  = 12'(TicksEndHighL);
   localparam logic [11:0] TICKS_ZERO      = 12'(TicksZeroL);
   localparam logic [11:0] TICKS_ONE       = 12'(TicksOneL);
   localparam logic [22:0] TICKS_PAUSE     = 23'(TicksPauseL);

   // Sample counts at 22050 Hz, rounded: (2*286*ticks + ns) / (2*ns).
   localparam longint unsigned CpuTickNs  = 64'd286;
   localparam longint unsigned SampleRate = 64'd44100 / 64'd2;
   localparam longint unsigned SampleNs   = 64'd1000000000 / SampleRate;
   localparam longint unsigned SmpDiv     = 64'd2 * SampleNs;

   localparam logic [3:0] SMP_PILOT_HIGH = 4'((2 * CpuTickNs * TicksPilotL + SampleNs) / SmpDiv);
   localparam logic [15:0] SMP_PILOT_LOW = 16'((2 * CpuTickNs * TicksPilotL + SampleNs) / SmpDiv);
   localparam logic [3:0] SMP_SYNC_HIGH =
      4'((2 * CpuTickNs * TicksSyncHighL + SampleNs) / SmpDiv);
   localparam logic [15:0] SMP_SYNC_LOW =
      16'((2 * CpuTickNs * TicksSyncLowL + SampleNs) / SmpDiv);
   localparam logic [3:0] SMP_END_HIGH =
      4'((2 * CpuTickNs * TicksEndHighL + SampleNs) / SmpDiv);
   localparam logic [15:0] SMP_PAUSE =
      16'((2 * CpuTickNs * TicksPauseL + SampleNs) / SmpDiv);
   localparam logic [3:0] SMP_ZERO_HIGH = 4'((2 * CpuTickNs * TicksZeroL + SampleNs) / SmpDiv);
   localparam logic [15:0] SMP_ZERO_LOW = 16'((2 * CpuTickNs * TicksZeroL + SampleNs) / SmpDiv);
   localparam logic [3:0] SMP_ONE_HIGH = 4'((2 * CpuTickNs * TicksOneL + SampleNs) / SmpDiv);
   localparam logic [15:0] SMP_ONE_LOW = 16'((2 * CpuTickNs * TicksOneL + SampleNs) / SmpDiv);

   // Default depth of the job queue between front and back.
   localparam int QUEUE_DEPTH = 2;

   // One job handed from the front to the back: a flag or data byte to send.
   typedef struct packed {
      logic       is_flag;
      logic       finish;
      logic [7:0] tap_byte;
   } job_type;

endpackage

`default_nettype wire

### rtl/tbpe_front.sv
// Front end: parses the block length and turns flag and data bytes into jobs.
`default_nettype none

module tbpe_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic [7:0]        req_tap_byte,
   input  wire logic              queue_full,
   output logic                   req_stall,
   output logic                   push,
   output tbpe_pkg::job_type      push_job
);

   typedef enum logic [3:0] {
      PH_LEN_LO = 4'b0001,
      PH_LEN_HI = 4'b0010,
      PH_FLAG   = 4'b0100,
      PH_DATA   = 4'b1000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] remain_ff, remain_in;
   logic        accept;
   logic [15:0] remain_dec;

   // A byte is taken whenever the queue has room.
   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   // Remaining count after this data byte, never going below zero.
   assign remain_dec = (remain_ff != 16'd0) ? (remain_ff - 16'd1) : 16'd0;

   // Classify the byte by parse phase and build the job for the back end.
   always_comb begin
      phase_in          = phase_ff;
      length_in         = length_ff;
      remain_in         = remain_ff;
      push              = 1'b0;
      push_job.is_flag  = 1'b0;
      push_job.finish   = 1'b0;
      push_job.tap_byte = req_tap_byte;
      case (phase_ff)
         PH_LEN_LO: begin
            if (accept) begin
               length_in = {8'd0, req_tap_byte};
               phase_in  = PH_LEN_HI;
            end
         end
         PH_LEN_HI: begin
            if (accept) begin
               length_in = {req_tap_byte, length_ff[7:0]};
               phase_in  = PH_FLAG;
            end
         end
         PH_FLAG: begin
            push             = accept;
            push_job.is_flag = 1'b1;
            push_job.finish  = (length_ff <= 16'd1);
            if (accept) begin
               if (length_ff <= 16'd1) begin
                  remain_in = 16'd0;
                  phase_in  = PH_LEN_LO;
               end else begin
                  remain_in = length_ff - 16'd1;
                  phase_in  = PH_DATA;
               end
            end
         end
         PH_DATA: begin
            push            = accept;
            push_job.finish = (remain_dec == 16'd0);
            if (accept) begin
               remain_in = remain_dec;
               if (remain_dec == 16'd0) begin
                  phase_in = PH_LEN_LO;
               end
            end
         end
         default: begin
            phase_in = PH_LEN_LO;
         end
      endcase
   end

   // Parse state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_LEN_LO;
         length_ff <= 16'd0;
         remain_ff <= 16'd0;
      end else begin
         phase_ff  <= phase_in;
         length_ff <= length_in;
         remain_ff <= remain_in;
      end
   end

endmodule

`default_nettype wire

### rtl/tbpe_queue.sv
// Short job queue that decouples the parsing front from the segment back end.
`default_nettype none

module tbpe_queue #(
   parameter int DEPTH = tbpe_pkg::QUEUE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  tbpe_pkg::job_type      push_job,
   input  wire logic              pop,
   output logic                   full,
   output logic                   not_empty,
   output tbpe_pkg::job_type      head_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   tbpe_pkg::job_type entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_job  = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // Pointer and fill count updates, wrapping at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : (wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : (rd_ptr_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

### rtl/tbpe_back.sv
// Back end: sequences pilot, sync, bit and end segments into the result register.
`default_nettype none

module tbpe_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              job_valid,
   input  tbpe_pkg::job_type      job,
   output logic                   pop,
   input  wire logic              rsp_stall,
   output logic                   rsp_valid,
   output logic [2:0]             rsp_segment_kind,
   output logic [11:0]            rsp_high_ticks,
   output logic [22:0]            rsp_low_ticks,
   output logic [12:0]            rsp_repeat_count,
   output logic [3:0]             rsp_high_samples,
   output logic [15:0]            rsp_low_samples,
   output logic                   rsp_last_of_run
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_PILOT = 5'b00010,
      ST_SYNC  = 5'b00100,
      ST_BITS  = 5'b01000,
      ST_END   = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   tbpe_pkg::job_type cur_ff, cur_in;
   logic [2:0]        bit_idx_ff, bit_idx_in;
   logic              valid_ff, valid_in;
   logic [2:0]        kind_ff, kind_in;
   logic [11:0]       high_ff, high_in;
   logic [22:0]       low_ff, low_in;
   logic [12:0]       rep_ff, rep_in;
   logic [3:0]        hsmp_ff, hsmp_in;
   logic [15:0]       lsmp_ff, lsmp_in;
   logic              last_ff, last_in;
   logic              out_free;
   logic              emit;
   logic              job_done;
   logic              cur_bit;

   // The result register can take a segment when empty or being drained.
   assign out_free = !valid_ff || !rsp_stall;
   assign emit     = out_free && (state_ff != ST_IDLE);
   assign cur_bit  = cur_ff.tap_byte[bit_idx_ff];

   // The current job ends with its last bit (no end segment) or with the end segment.
   assign job_done = emit && ((state_ff == ST_END) ||
                              ((state_ff == ST_BITS) && (bit_idx_ff == 3'd0) && !cur_ff.finish));

   // Take the next job as soon as the previous one has sent its final segment.
   assign pop = job_valid && ((state_ff == ST_IDLE) || job_done);

   // Segment fields for the current step.
   always_comb begin
      kind_in = tbpe_pkg::KIND_END;
      high_in = tbpe_pkg::TICKS_END_HIGH;
      low_in  = tbpe_pkg::TICKS_PAUSE;
      rep_in  = tbpe_pkg::SINGLE_COUNT;
      hsmp_in = tbpe_pkg::SMP_END_HIGH;
      lsmp_in = tbpe_pkg::SMP_PAUSE;
      last_in = 1'b1;
      case (state_ff)
         ST_PILOT: begin
            kind_in = tbpe_pkg::KIND_PILOT;
            high_in = tbpe_pkg::TICKS_PILOT;
            low_in  = 23'(tbpe_pkg::TICKS_PILOT);
            rep_in  = (cur_ff.tap_byte != 8'd0) ? tbpe_pkg::PILOT_DATA_COUNT
                                                : tbpe_pkg::PILOT_HEADER_COUNT;
            hsmp_in = tbpe_pkg::SMP_PILOT_HIGH;
            lsmp_in = tbpe_pkg::SMP_PILOT_LOW;
            last_in = 1'b0;
         end
         ST_SYNC: begin
            kind_in = tbpe_pkg::KIND_SYNC;
            high_in = tbpe_pkg::TICKS_SYNC_HIGH;
            low_in  = tbpe_pkg::TICKS_SYNC_LOW;
            hsmp_in = tbpe_pkg::SMP_SYNC_HIGH;
            lsmp_in = tbpe_pkg::SMP_SYNC_LOW;
            last_in = 1'b0;
         end
         ST_BITS: begin
            if (cur_bit) begin
               kind_in = tbpe_pkg::KIND_ONE;
               high_in = tbpe_pkg::TICKS_ONE;
               low_in  = 23'(tbpe_pkg::TICKS_ONE);
               hsmp_in = tbpe_pkg::SMP_ONE_HIGH;
               lsmp_in = tbpe_pkg::SMP_ONE_LOW;
            end else begin
               kind_in = tbpe_pkg::KIND_ZERO;
               high_in = tbpe_pkg::TICKS_ZERO;
               low_in  = 23'(tbpe_pkg::TICKS_ZERO);
               hsmp_in = tbpe_pkg::SMP_ZERO_HIGH;
               lsmp_in = tbpe_pkg::SMP_ZERO_LOW;
            end
            last_in = (bit_idx_ff == 3'd0) && !cur_ff.finish;
         end
         default: begin
            kind_in = tbpe_pkg::KIND_END;
         end
      endcase
   end

   // Sequencer: step through the segments of a job, loading the next job on completion.
   always_comb begin
      state_in   = state_ff;
      cur_in     = cur_ff;
      bit_idx_in = bit_idx_ff;
      if (emit) begin
         case (state_ff)
            ST_PILOT: begin
               state_in = ST_SYNC;
            end
            ST_SYNC: begin
               state_in   = ST_BITS;
               bit_idx_in = 3'd7;
            end
            ST_BITS: begin
               if (bit_idx_ff != 3'd0) begin
                  bit_idx_in = bit_idx_ff - 3'd1;
               end else if (cur_ff.finish) begin
                  state_in = ST_END;
               end else begin
                  state_in = ST_IDLE;
               end
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
      if (pop) begin
         cur_in     = job;
         bit_idx_in = 3'd7;
         state_in   = job.is_flag ? ST_PILOT : ST_BITS;
      end
   end

   // Result register valid flag.
   always_comb begin
      valid_in = valid_ff;
      if (emit) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         bit_idx_ff <= 3'd7;
         valid_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         bit_idx_ff <= bit_idx_in;
         valid_ff   <= valid_in;
      end
   end

   // Job and result payload registers.
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (emit) begin
         kind_ff <= kind_in;
         high_ff <= high_in;
         low_ff  <= low_in;
         rep_ff  <= rep_in;
         hsmp_ff <= hsmp_in;
         lsmp_ff <= lsmp_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_segment_kind = kind_ff;
   assign rsp_high_ticks   = high_ff;
   assign rsp_low_ticks    = low_ff;
   assign rsp_repeat_count = rep_ff;
   assign rsp_high_samples = hsmp_ff;
   assign rsp_low_samples  = lsmp_ff;
   assign rsp_last_of_run  = last_ff;

endmodule

`default_nettype wire

### rtl/tape_block_pulse_encoder_top.sv
// Top level of the tape block pulse encoder: front, job queue and segment back end.
//
// Usage: tape-image bytes enter on the req_ channel, one per transfer. Each block
// opens with a two-byte little-endian length, then the flag byte and the data bytes.
// Length bytes produce no result. The flag byte produces a pilot segment, a sync
// segment and eight bit segments; each data byte produces eight bit segments. The
// last byte of a block adds an end segment. Results leave on the rsp_ channel, one
// segment per transfer, with rsp_last_of_run marking the final segment of a byte.
// The first segment of a byte passes through the job queue, the job register and
// the result register. Throughput: while the receiver does not stall and the queue has jobs,
// the back sequencer emits one segment per cycle; a flag byte yields 10 or 11 segments, a
// data byte 8 or 9, and the job queue lets the front accept bytes while the back is still busy.
// Reset clears the parse state, the queue and the result valid flag; the first byte
// after reset is the low length byte. When the receiver stalls, the result register
// holds its segment, the back end waits and the queue fills; once it is full,
// req_stall is raised until an entry is taken.
`default_nettype none

module tape_block_pulse_encoder_top #(
   parameter int QUEUE_DEPTH = tbpe_pkg::QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_tap_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_segment_kind,
   output logic [11:0]      rsp_high_ticks,
   output logic [22:0]      rsp_low_ticks,
   output logic [12:0]      rsp_repeat_count,
   output logic [3:0]       rsp_high_samples,
   output logic [15:0]      rsp_low_samples,
   output logic             rsp_last_of_run
);

   logic              q_push;
   logic              q_full;
   logic              q_not_empty;
   logic              q_pop;
   tbpe_pkg::job_type q_push_job;
   tbpe_pkg::job_type q_head_job;

   // Front end: byte parsing and job creation.
   tbpe_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_tap_byte (req_tap_byte),
      .queue_full   (q_full),
      .req_stall    (req_stall),
      .push         (q_push),
      .push_job     (q_push_job)
   );

   // Job queue between front and back.
   tbpe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_job  (q_push_job),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_job  (q_head_job)
   );

   // Back end: segment sequencing and result register.
   tbpe_back u_back (
      .clock            (clock),
      .reset            (reset),
      .job_valid        (q_not_empty),
      .job              (q_head_job),
      .pop              (q_pop),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_segment_kind (rsp_segment_kind),
      .rsp_high_ticks   (rsp_high_ticks),
      .rsp_low_ticks    (rsp_low_ticks),
      .rsp_repeat_count (rsp_repeat_count),
      .rsp_high_samples (rsp_high_samples),
      .rsp_low_samples  (rsp_low_samples),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   // The end segment always closes the run of its byte.
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_segment_kind == tbpe_pkg::KIND_END)) |-> rsp_last_of_run)
      else $error("End segment without last_of_run.");

   // Only pilot segments repeat, and then with one of the two pilot counts.
   a_repeat_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_segment_kind != tbpe_pkg::KIND_PILOT)) |->
         (rsp_repeat_count == tbpe_pkg::SINGLE_COUNT))
      else $error("Non-pilot segment with a repeat count other than one.");

   a_pilot_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_segment_kind == tbpe_pkg::KIND_PILOT)) |->
         ((rsp_repeat_count == tbpe_pkg::PILOT_DATA_COUNT) ||
          (rsp_repeat_count == tbpe_pkg::PILOT_HEADER_COUNT)))
      else $error("Pilot segment with an unexpected repeat count.");

   // A pop is only issued when the queue holds a job.
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_not_empty)
      else $error("Job taken from an empty queue.");

endmodule

`default_nettype wire

### bench/tape_segment_checker.sv
// Checker that predicts the pulse segments of the tape encoder and compares every result transfer.
module tape_segment_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [7:0]  req_tap_byte,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [2:0]  rsp_segment_kind,
   input  wire logic [11:0] rsp_high_ticks,
   input  wire logic [22:0] rsp_low_ticks,
   input  wire logic [12:0] rsp_repeat_count,
   input  wire logic [3:0]  rsp_high_samples,
   input  wire logic [15:0] rsp_low_samples,
   input  wire logic        rsp_last_of_run,
   output int               mismatch_count,
   output int               segments_due,
   output int               segments_checked,
   output int               bytes_taken,
   output int               end_segments
);
   timeunit 1ns;
   timeprecision 1ps;

   // Tape timing in CPU ticks and the pilot lengths of header and data blocks.
   localparam logic [11:0] PILOT_TICKS     = 12'd2168;
   localparam logic [11:0] SYNC_HIGH_TICKS = 12'd667;
   localparam logic [22:0] SYNC_LOW_TICKS  = 23'd735;
   localparam logic [11:0] END_HIGH_TICKS  = 12'd954;
   localparam logic [11:0] ZERO_BIT_TICKS  = 12'd855;
   localparam logic [11:0] ONE_BIT_TICKS   = 12'd1710;
   localparam logic [22:0] PAUSE_TICKS     = 23'd6987464;
   localparam logic [12:0] HEADER_PILOTS   = 13'd8063;
   localparam logic [12:0] DATA_PILOTS     = 13'd3223;

   typedef enum logic [1:0] {
      EXPECT_LEN_LO,
      EXPECT_LEN_HI,
      EXPECT_FLAG,
      EXPECT_DATA
   } parse_phase_type;

   typedef struct packed {
      logic [2:0]  segment_kind;
      logic [11:0] high_ticks;
      logic [22:0] low_ticks;
      logic [12:0] repeat_count;
      logic [3:0]  high_samples;
      logic [15:0] low_samples;
      logic        last_of_run;
   } pulse_segment_type;

   parse_phase_type   phase;
   logic [15:0]       block_length;
   logic [15:0]       bytes_left;
   pulse_segment_type expected_segments[$];
   pulse_segment_type want;
   int                mismatches;
   int                checked;
   int                taken;
   int                ends_seen;

   // Rounded audio samples at 22050 Hz for a length in ticks, in exact integer form.
   function automatic logic [15:0] ticks_to_samples(input longint unsigned ticks);
      return 16'((64'd572 * ticks + 64'd45351) / 64'd90702);
   endfunction

   function automatic pulse_segment_type make_segment(input logic [2:0] kind,
                                                      input logic [11:0] high,
                                                      input logic [22:0] low,
                                                      input logic [12:0] repeats);
      pulse_segment_type seg;
      seg.segment_kind = kind;
      seg.high_ticks   = high;
      seg.low_ticks    = low;
      seg.repeat_count = repeats;
      seg.high_samples = 4'(ticks_to_samples(longint'(high)));
      seg.low_samples  = ticks_to_samples(longint'(low));
      seg.last_of_run  = 1'b0;
      return seg;
   endfunction

   // Eight bit segments, most significant bit first.
   task automatic queue_bit_segments(input logic [7:0] value);
      for (int i = 7; i >= 0; i--) begin
         if (value[i]) begin
            expected_segments.push_back(make_segment(tbpe_pkg::KIND_ONE, ONE_BIT_TICKS,
                                                     23'(ONE_BIT_TICKS), 13'd1));
         end else begin
            expected_segments.push_back(make_segment(tbpe_pkg::KIND_ZERO, ZERO_BIT_TICKS,
                                                     23'(ZERO_BIT_TICKS), 13'd1));
         end
      end
   endtask

   // Works out every segment that one tape byte causes and advances the block parser.
   task automatic encode_tape_byte(input logic [7:0] value);
      int                before_count;
      bit                block_done;
      pulse_segment_type tail;
      before_count = expected_segments.size();
      block_done   = 1'b0;
      case (phase)
         EXPECT_LEN_LO: begin
            block_length = {8'h00, value};
            phase        = EXPECT_LEN_HI;
         end
         EXPECT_LEN_HI: begin
            block_length[15:8] = value;
            phase              = EXPECT_FLAG;
         end
         EXPECT_FLAG: begin
            expected_segments.push_back(make_segment(tbpe_pkg::KIND_PILOT, PILOT_TICKS,
               23'(PILOT_TICKS), (value != 8'h00) ? DATA_PILOTS : HEADER_PILOTS));
            expected_segments.push_back(make_segment(tbpe_pkg::KIND_SYNC, SYNC_HIGH_TICKS,
                                                     SYNC_LOW_TICKS, 13'd1));
            queue_bit_segments(value);
            // A length of zero behaves like a length of one.
            if (block_length <= 16'd1) begin
               bytes_left = 16'd0;
               block_done = 1'b1;
            end else begin
               bytes_left = block_length - 16'd1;
               phase      = EXPECT_DATA;
            end
         end
         default: begin
            queue_bit_segments(value);
            if (bytes_left > 16'd0) bytes_left = bytes_left - 16'd1;
            if (bytes_left == 16'd0) block_done = 1'b1;
         end
      endcase
      if (block_done) begin
         expected_segments.push_back(make_segment(tbpe_pkg::KIND_END, END_HIGH_TICKS,
                                                  PAUSE_TICKS, 13'd1));
         phase = EXPECT_LEN_LO;
      end
      // The final segment of the byte carries the end-of-run marker.
      if (expected_segments.size() > before_count) begin
         tail = expected_segments.pop_back();
         tail.last_of_run = 1'b1;
         expected_segments.push_back(tail);
      end
   endtask

   function automatic void check_field(input string field, input longint unsigned expected_value,
                                       input longint unsigned actual_value);
      if (expected_value != actual_value) begin
         $error("%s: expected %0d, got %0d", field, expected_value, actual_value);
         mismatches++;
      end
   endfunction

   // Prediction on each input transfer, comparison on each result transfer.
   always @(posedge clock) begin
      if (reset) begin
         phase        = EXPECT_LEN_LO;
         block_length = 16'd0;
         bytes_left   = 16'd0;
         expected_segments.delete();
         mismatches   = 0;
         checked      = 0;
         taken        = 0;
         ends_seen    = 0;
      end else begin
         if (req_valid && !req_stall) begin
            encode_tape_byte(req_tap_byte);
            taken++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_segments.size() == 0) begin
               $error("segment_kind: expected no segment, got %0d", rsp_segment_kind);
               mismatches++;
            end else begin
               want = expected_segments.pop_front();
               check_field("segment_kind", want.segment_kind, rsp_segment_kind);
               check_field("high_ticks", want.high_ticks, rsp_high_ticks);
               check_field("low_ticks", want.low_ticks, rsp_low_ticks);
               check_field("repeat_count", want.repeat_count, rsp_repeat_count);
               check_field("high_samples", want.high_samples, rsp_high_samples);
               check_field("low_samples", want.low_samples, rsp_low_samples);
               check_field("last_of_run", want.last_of_run, rsp_last_of_run);
               checked++;
               if (want.segment_kind == tbpe_pkg::KIND_END) ends_seen++;
            end
         end
      end
      mismatch_count   <= mismatches;
      segments_due     <= expected_segments.size();
      segments_checked <= checked;
      bytes_taken      <= taken;
      end_segments     <= ends_seen;
   end

endmodule

### bench/tape_block_pulse_encoder_top_test.sv
// Testbench top for the tape pulse encoder: clock, reset, byte stimulus, receiver and verdict.
module tape_block_pulse_encoder_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS      = 200;
   localparam int RSP_HOLD_CYCLES   = 200;
   localparam int IDLE_LIMIT_CYCLES = 3000;
   localparam int SETTLE_CYCLES     = 20;
   localparam int DIRECTED_LENGTH   = 21;

   // Hand-picked blocks: zero length, single byte, short blocks with extreme data patterns.
   localparam logic [7:0] DIRECTED_STREAM [DIRECTED_LENGTH] = '{
      8'h00, 8'h00, 8'h00,
      8'h01, 8'h00, 8'hFF,
      8'h02, 8'h00, 8'h80, 8'h01,
      8'h04, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hA5,
      8'h03, 8'h00, 8'h5A, 8'h7F, 8'h80
   };

   logic        clock        = 1'b0;
   logic        reset        = 1'b1;
   logic        req_valid    = 1'b0;
   logic [7:0]  req_tap_byte = 8'h00;
   logic        rsp_stall    = 1'b0;
   logic        req_stall;
   logic        rsp_valid;
   logic [2:0]  rsp_segment_kind;
   logic [11:0] rsp_high_ticks;
   logic [22:0] rsp_low_ticks;
   logic [12:0] rsp_repeat_count;
   logic [3:0]  rsp_high_samples;
   logic [15:0] rsp_low_samples;
   logic        rsp_last_of_run;

   int mismatch_count;
   int segments_due;
   int segments_checked;
   int bytes_taken;
   int end_segments;
   int idle_cycles = 0;
   bit calm_stretch = 1'b0;
   bit hold_requested = 1'b0;

   always #5ns clock = ~clock;

   tape_block_pulse_encoder_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_tap_byte     (req_tap_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_segment_kind (rsp_segment_kind),
      .rsp_high_ticks   (rsp_high_ticks),
      .rsp_low_ticks    (rsp_low_ticks),
      .rsp_repeat_count (rsp_repeat_count),
      .rsp_high_samples (rsp_high_samples),
      .rsp_low_samples  (rsp_low_samples),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   tape_segment_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_tap_byte     (req_tap_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_segment_kind (rsp_segment_kind),
      .rsp_high_ticks   (rsp_high_ticks),
      .rsp_low_ticks    (rsp_low_ticks),
      .rsp_repeat_count (rsp_repeat_count),
      .rsp_high_samples (rsp_high_samples),
      .rsp_low_samples  (rsp_low_samples),
      .rsp_last_of_run  (rsp_last_of_run),
      .mismatch_count   (mismatch_count),
      .segments_due     (segments_due),
      .segments_checked (segments_checked),
      .bytes_taken      (bytes_taken),
      .end_segments     (end_segments)
   );

   // Offers one tape byte after a random gap and returns once its transfer has happened.
   task automatic send_tape_byte(input logic [7:0] value);
      while (!calm_stretch && ($urandom_range(99) < 13)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_tap_byte <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Stops offering and waits until every predicted segment has been received.
   task automatic wait_for_segments();
      req_valid <= 1'b0;
      @(posedge clock);
      while (segments_due != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] random_data_byte();
      int pick;
      pick = $urandom_range(99);
      if (pick < 20) return 8'h00;
      if (pick < 40) return 8'hFF;
      return 8'($urandom_range(255));
   endfunction

   // Receiver: random stalls, one long hold-off on request, none during the calm stretch.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_requested) begin
            hold_requested = 1'b0;
            rsp_stall <= 1'b1;
            repeat (RSP_HOLD_CYCLES - 1) @(posedge clock);
         end else begin
            rsp_stall <= !calm_stretch && ($urandom_range(99) < 13);
         end
      end
   end

   // Watchdog: ends the run if no transfer happens on either channel for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT_CYCLES) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Stimulus: directed blocks, a drained pause, random blocks, then a truncated block.
   initial begin
      int          data_sent;
      int          pick;
      logic [15:0] length;
      logic [7:0]  flag;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED_STREAM[i]) send_tape_byte(DIRECTED_STREAM[i]);
      wait_for_segments();

      // The receiver holds off while the sender keeps offering, so the queue fills up.
      hold_requested = 1'b1;
      data_sent = 0;
      while (data_sent < RANDOM_ITEMS) begin
         calm_stretch = (data_sent >= 90) && (data_sent < 150);
         pick = $urandom_range(99);
         if (pick < 70) length = 16'($urandom_range(6));
         else if (pick < 90) length = 16'($urandom_range(16, 7));
         else length = 16'($urandom_range(40, 17));
         flag = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(255, 1));
         send_tape_byte(length[7:0]);
         send_tape_byte(length[15:8]);
         send_tape_byte(flag);
         for (int i = 1; i < int'(length); i++) send_tape_byte(random_data_byte());
         // Two length bytes, then the flag byte and the data bytes.
         data_sent += 2 + ((length == 16'd0) ? 1 : int'(length));
      end
      calm_stretch = 1'b0;

      // A block of the largest length that never completes, so no end segment follows.
      send_tape_byte(8'hFF);
      send_tape_byte(8'hFF);
      send_tape_byte(8'($urandom_range(255)));
      repeat (3) send_tape_byte(random_data_byte());

      wait_for_segments();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Run covered %0d tape bytes and %0d checked segments, %0d of them end segments.",
               bytes_taken, segments_checked, end_segments);
      $display("Zero-length, header and data blocks, a long receiver hold-off, a truncated block.");
      if (mismatch_count == 0 && segments_due == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
